// ===== src/tkc_pkg.sv =====
// Package: word types, register indexes and control structs for the top-k selector.
package tkc_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT = 1'd1;

  localparam logic MODE_CHRONO     = 1'b0;
  localparam logic MODE_POPULARITY = 1'b1;

  typedef struct packed {
    logic [31:0] record_id;
    logic [31:0] popularity;
    logic        list_end;
  } rec_t;

  typedef struct packed {
    logic [31:0] out_id;
    logic [31:0] out_popularity;
    logic [4:0]  out_rank;
    logic        out_last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic drain_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mode;
    logic drain_last;
  } dp_sts_t;

endpackage

// ===== src/tkc_ctrl.sv =====
// Controller: accept / drain sequencing for the top-k selector.
module tkc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           list_end,
  input  tkc_pkg::dp_sts_t sts,
  output logic           busy,
  output tkc_pkg::dp_cmd_t cmd
);
  import tkc_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state, state_next;

  always_comb begin
    state_next     = state;
    cmd.accept     = 1'b0;
    cmd.drain_step = 1'b0;
    busy           = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && list_end && sts.mode == MODE_POPULARITY) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        busy           = 1'b1;
        cmd.drain_step = 1'b1;
        if (sts.drain_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/tkc_datapath.sv =====
// Datapath: config registers, sorted cell chain, counters and result register.
module tkc_datapath #(
  parameter int CAPACITY = tkc_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tkc_pkg::dp_cmd_t               cmd,
  output tkc_pkg::dp_sts_t               sts,
  input  tkc_pkg::rec_t                  rec,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tkc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [5:0]                     cfg_data,
  output logic                           res_valid,
  output tkc_pkg::res_t                  res
);
  import tkc_pkg::*;

  localparam int FW = $clog2(CAPACITY + 1);

  logic        order_mode;
  logic [5:0]  keep_limit;

  logic [31:0] cell_id  [CAPACITY];
  logic [31:0] cell_cnt [CAPACITY];
  logic [FW-1:0] fill, seen, rank;
  logic [FW-1:0] k_lim, f_eff, new_fill;

  logic [CAPACITY-1:0] valid, take;
  logic full, do_ins, drain_last, chrono_emit;

  assign cfg_ready = 1'b1;

  // effective limit: 0 or above capacity means capacity
  always_comb begin
    if (keep_limit == '0 || 32'(keep_limit) > CAPACITY) begin
      k_lim = FW'(CAPACITY);
    end else begin
      k_lim = FW'(keep_limit);
    end
  end

  assign f_eff = (fill > k_lim) ? k_lim : fill;

  // per-cell keep test; sorted chain makes take a prefix
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = FW'(i) < f_eff;
      take[i]  = valid[i] && (cell_cnt[i] >= rec.popularity);
    end
  end

  assign full     = f_eff >= k_lim;
  assign do_ins   = !full || !(&(take | ~valid));
  assign new_fill = full ? f_eff : f_eff + 1'b1;

  assign drain_last  = rank == fill - 1'b1;
  assign chrono_emit = seen < k_lim;

  assign sts.mode       = order_mode;
  assign sts.drain_last = drain_last;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= MODE_CHRONO;
      keep_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORDER_MODE: order_mode <= cfg_data[0];
        REG_KEEP_LIMIT: keep_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell chain: parallel insert, shift towards cell 0 while draining
  always_ff @(posedge clk) begin
    if (cmd.accept && order_mode == MODE_POPULARITY && do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!take[i]) begin
          if (i == 0 || take[(i == 0) ? 0 : i - 1]) begin
            cell_id[i]  <= rec.record_id;
            cell_cnt[i] <= rec.popularity;
          end else begin
            cell_id[i]  <= cell_id[(i == 0) ? 0 : i - 1];
            cell_cnt[i] <= cell_cnt[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (cmd.drain_step) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cell_id[i]  <= cell_id[i + 1];
        cell_cnt[i] <= cell_cnt[i + 1];
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      seen <= '0;
      rank <= '0;
    end else if (cmd.accept) begin
      if (order_mode == MODE_POPULARITY) begin
        fill <= do_ins ? new_fill : f_eff;
      end else if (rec.list_end) begin
        fill <= '0;
      end
      if (rec.list_end) begin
        seen <= '0;
      end else if (32'(seen) < CAPACITY) begin
        seen <= seen + 1'b1;
      end
      rank <= '0;
    end else if (cmd.drain_step) begin
      if (drain_last) begin
        fill <= '0;
        rank <= '0;
      end else begin
        rank <= rank + 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.drain_step ||
                   (cmd.accept && order_mode == MODE_CHRONO && chrono_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_step) begin
      res.out_id         <= cell_id[0];
      res.out_popularity <= cell_cnt[0];
      res.out_rank       <= 5'(rank);
      res.out_last       <= drain_last;
    end else if (cmd.accept) begin
      res.out_id         <= rec.record_id;
      res.out_popularity <= rec.popularity;
      res.out_rank       <= 5'(seen);
      res.out_last       <= rec.list_end || (seen + 1'b1 == k_lim);
    end
  end

  // drain only runs over a non-empty chain
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_step |-> fill != '0)
    else $error("drain with empty chain");

  // each drain step delivers a word next cycle
  a_drain_word: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_step |=> res_valid)
    else $error("drain step gave no word");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= CAPACITY)
    else $error("fill beyond capacity");

  // last drained word ends the run and empties the chain
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.drain_step && drain_last) |=> (res.out_last && fill == '0))
    else $error("drain end mismatch");

endmodule

// ===== src/top_k_by_count_selector.sv =====
// Top level: top-k selector by popularity count.
//
// Records arrive on rec, one word per clock, taken when start is high and busy
// is low. In chronological mode (order_mode 0) the first k records of a list
// come straight back on res in the cycle after acceptance, and a new record
// can be taken every cycle. In popularity mode (order_mode 1) each record is
// inserted into a sorted chain of CAPACITY cells in the accepting cycle, every
// cell comparing its count with the new one in parallel, so records also go in
// at one per cycle. On the record marked list_end the chain drains: busy stays
// high while the kept records (at most k) leave as result words, one per cycle,
// best count first, ties in arrival order; the drain length is what sets the
// extra latency at list end. k is keep_limit, or CAPACITY when keep_limit is
// 0 or larger than CAPACITY. Result words sit on res for exactly one cycle with
// res_valid high; the receiver cannot stall them, so it must take every strobe.
// Configuration writes (index 0 order_mode, index 1 keep_limit) are always ready
// and are meant to be issued only while the block is idle.
module top_k_by_count_selector #(
  parameter int CAPACITY = tkc_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // record channel
  input  logic                           start,
  output logic                           busy,
  input  tkc_pkg::rec_t                  rec,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tkc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [5:0]                     cfg_data,
  // result words
  output logic                           res_valid,
  output tkc_pkg::res_t                  res
);
  import tkc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: accept in idle, drain on list end in popularity mode
  tkc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .list_end (rec.list_end),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  // cell chain, counters, config registers, result register
  tkc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .rec       (rec),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule
